// ----- hdl/gcc_phat_steered_score_defines.svh -----
// Assertion macros shared by the checker files.
`ifndef GCC_PHAT_STEERED_SCORE_DEFINES_SVH
`define GCC_PHAT_STEERED_SCORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GPSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gpss_pkg.sv -----
// ----------------------------------------------------------------------------
// gpss_pkg
// Types, sizes and codes of the steered GCC-PHAT score block.
// ----------------------------------------------------------------------------
package gpss_pkg;

  localparam int ANGLES = 32;
  localparam int BINS   = 256;
  localparam int PAIRS  = 8;
  localparam int DEPTH  = ANGLES * BINS * PAIRS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int SQRT_STEPS = 32;  // result bits of a 64-bit radicand
  localparam int QUOT_BITS  = 17;  // |term| < 2^17
  localparam int SUM_W      = 20;

  typedef enum logic {
    OP_ACC   = 1'b0,
    OP_WRITE = 1'b1
  } gpss_op_e;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         angle_index;
    logic [7:0]         bin_index;
    logic [2:0]         pair_index;
    logic signed [15:0] first_re;
    logic signed [15:0] first_im;
    logic signed [15:0] second_re;
    logic signed [15:0] second_im;
    logic signed [15:0] steer_re;
    logic signed [15:0] steer_im;
    logic               last_pair;
  } gpss_in_t;

  typedef struct packed {
    logic signed [19:0] score;
    logic [3:0]         skipped_terms;
  } gpss_out_t;

  // classified command handed from front to back
  typedef struct packed {
    gpss_op_e           op;
    logic               in_range;
    logic [ADDR_W-1:0]  addr;
    logic               last;
    logic signed [32:0] pr;
    logic signed [32:0] pi;
    logic [31:0]        steer;
  } gpss_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SQRT,
    ST_DSET,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } gpss_state_e;

endpackage

// ----- hdl/gpss_front.sv -----
// ----------------------------------------------------------------------------
// gpss_front
// Accepts items, forms the cross-spectrum and table address, classifies.
// ----------------------------------------------------------------------------
module gpss_front import gpss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gpss_in_t  in_item_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output gpss_cmd_t push_cmd_o
);

  logic      s_valid_q;
  gpss_cmd_t s_q, s_d;
  logic signed [31:0] m_rr, m_ii, m_ir, m_ri;

  assign in_ready_o   = !s_valid_q || push_ready_i;
  assign push_valid_o = s_valid_q;
  assign push_cmd_o   = s_q;

  // 16x16 products are exact in 32 bits
  assign m_rr = in_item_i.first_re * in_item_i.second_re;
  assign m_ii = in_item_i.first_im * in_item_i.second_im;
  assign m_ir = in_item_i.first_im * in_item_i.second_re;
  assign m_ri = in_item_i.first_re * in_item_i.second_im;

  always_comb begin
    s_d.op       = gpss_op_e'(in_item_i.opcode);
    s_d.in_range = (32'(in_item_i.angle_index) < ANGLES) &&
                   (32'(in_item_i.bin_index) < BINS) &&
                   (32'(in_item_i.pair_index) < PAIRS);
    s_d.addr     = ADDR_W'((32'(in_item_i.angle_index) * BINS +
                   32'(in_item_i.bin_index)) * PAIRS + 32'(in_item_i.pair_index));
    s_d.last     = in_item_i.last_pair;
    s_d.pr       = 33'(m_rr) + 33'(m_ii);
    s_d.pi       = 33'(m_ir) - 33'(m_ri);
    s_d.steer    = {in_item_i.steer_re, in_item_i.steer_im};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s_q <= s_d;
    end
  end

endmodule

// ----- hdl/gpss_fifo.sv -----
// ----------------------------------------------------------------------------
// gpss_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module gpss_fifo import gpss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  gpss_cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  logic      pop_i,
  output gpss_cmd_t pop_cmd_o
);

  gpss_cmd_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hdl/gpss_back.sv -----
// ----------------------------------------------------------------------------
// gpss_back
// Table, magnitude square root, divide, accumulate and result register.
// ----------------------------------------------------------------------------
module gpss_back import gpss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  gpss_cmd_t cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gpss_out_t out_item_o
);

  gpss_state_e state_q, state_d;

  logic [31:0] table_mem [DEPTH];
  logic [31:0] rd_q;
  logic        mem_we, out_load;

  gpss_cmd_t          cmd_q;
  logic [63:0]        sqa_q, sqb_q, rad_q, res_q, bit_v, trial;
  logic signed [48:0] np_q, nq_q;
  logic signed [49:0] num;
  logic [48:0]        rem_q, dv_q;
  logic               neg_q, ge;
  logic [QUOT_BITS-1:0] quo_q;
  logic [4:0]         cnt_q;
  logic [31:0]        apr, api;
  logic signed [15:0] sr, si;
  logic signed [QUOT_BITS:0] term;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W-1:0]   sum_q;
  logic [3:0]         skip_q;
  logic               out_valid_q;
  gpss_out_t          out_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_valid_i && cmd_i.op == OP_ACC) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_SQRT;
      ST_SQRT: if (cnt_q == 5'd0) state_d = ST_DSET;
      ST_DSET: state_d = (res_q == 64'd0) ? ST_ACC : ST_DIV;
      ST_DIV:  if (cnt_q == 5'd0) state_d = ST_ACC;
      ST_ACC:  state_d = cmd_q.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        mem_we    = cmd_valid_i && cmd_i.op == OP_WRITE && cmd_i.in_range;
      end
      ST_EMIT: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) table_mem[cmd_i.addr] <= cmd_i.steer;
    rd_q <= table_mem[cmd_i.addr];
  end

  // datapath helpers
  assign sr    = cmd_q.in_range ? $signed(rd_q[31:16]) : 16'sd0;
  assign si    = cmd_q.in_range ? $signed(rd_q[15:0])  : 16'sd0;
  assign apr   = cmd_q.pr[32] ? 32'(-cmd_q.pr) : 32'(cmd_q.pr);
  assign api   = cmd_q.pi[32] ? 32'(-cmd_q.pi) : 32'(cmd_q.pi);
  assign num   = 50'(np_q) - 50'(nq_q);
  assign bit_v = 64'd1 << {cnt_q, 1'b0};
  assign trial = res_q + bit_v;
  assign ge    = rem_q >= dv_q;
  assign term  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(term);

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (cmd_pop_o) cmd_q <= cmd_i;
      ST_MUL: begin
        sqa_q <= 64'(apr) * 64'(apr);
        sqb_q <= 64'(api) * 64'(api);
        np_q  <= 49'(cmd_q.pr) * 49'(sr);
        nq_q  <= 49'(cmd_q.pi) * 49'(si);
      end
      ST_SUM: begin
        rad_q <= sqa_q + sqb_q;
        res_q <= 64'd0;
        neg_q <= num[49];
        rem_q <= num[49] ? 49'(-num) : 49'(num);
        cnt_q <= 5'(SQRT_STEPS - 1);
      end
      ST_SQRT: begin
        if (rad_q >= trial) begin
          rad_q <= rad_q - trial;
          res_q <= (res_q >> 1) + bit_v;
        end else begin
          res_q <= res_q >> 1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
      ST_DSET: begin
        dv_q  <= {1'b0, res_q[31:0], 16'd0};
        quo_q <= '0;
        cnt_q <= 5'(QUOT_BITS - 1);
      end
      ST_DIV: begin
        if (ge) rem_q <= rem_q - dv_q;
        quo_q <= {quo_q[QUOT_BITS-2:0], ge};
        dv_q  <= dv_q >> 1;
        cnt_q <= cnt_q - 5'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.score         <= sum_q;
      out_q.skipped_terms <= skip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        if (res_q == 64'd0) begin
          if (skip_q != 4'd15) skip_q <= skip_q + 4'd1;
        end else if (sum_ext > (SUM_W+1)'(524287)) begin
          sum_q <= SUM_W'(524287);
        end else if (sum_ext < -(SUM_W+1)'(524288)) begin
          sum_q <= -SUM_W'(524288);
        end else begin
          sum_q <= SUM_W'(sum_ext);
        end
      end
      if (out_load) begin
        sum_q       <= '0;
        skip_q      <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/gcc_phat_steered_score.sv -----
// Flow: a write item passes the front register and the queue, and the back
// writes the table from ST_IDLE; an accumulate item runs ST_MUL, ST_SUM, a 32-step
// square root, ST_DSET, a 17-step divider (skipped for a zero-magnitude term) and
// ST_ACC, then ST_EMIT loads the result register on a last pair. The back takes a
// new item only in ST_IDLE; writes go one per cycle while the back is idle.
// Reset: asynchronous, clears queue, sum, skip count and result valid.
// ----------------------------------------------------------------------------
// gcc_phat_steered_score
// Steered GCC-PHAT score for one bin and angle: front classifies, a two-entry
// queue decouples, back normalizes and accumulates. The steering table has no
// reset; entries read before being written are undefined.
// ----------------------------------------------------------------------------
module gcc_phat_steered_score import gpss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gpss_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gpss_out_t out_item_o
);

  logic      push_valid, push_ready;
  gpss_cmd_t push_cmd, pop_cmd;
  logic      pop_valid, pop;

  // front: cross-spectrum products and address decode, one item per cycle while the queue has room
  gpss_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // queue lets the front keep taking items while the back iterates
  gpss_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  // back: table, sqrt, divide, saturating sum, result register
  gpss_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (pop_valid),
    .cmd_pop_o   (pop),
    .cmd_i       (pop_cmd),
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

endmodule

// ----- hdl/gpss_checker.sv -----
// ----------------------------------------------------------------------------
// gpss_checker
// Port-level checks of the steered score block.
// ----------------------------------------------------------------------------
`include "gcc_phat_steered_score_defines.svh"

module gpss_checker import gpss_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input gpss_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input gpss_out_t out_item_o
);

  `GPSS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `GPSS_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_item_o), "result changed")
  // a waiting input item stays offered and unchanged
  `GPSS_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_item_i), "input item dropped")
  `GPSS_ASSERT_NOW(a_out_known, 1'b1, !$isunknown(out_valid_o), "result valid unknown")

endmodule

bind gcc_phat_steered_score gpss_checker u_checker (.*);
